// ===== src/gf256_poly_inverse_mod_x4_plus_1_macros.svh =====
// Assertion macros shared by the gf256 polynomial inverse block.
// Needs clk and rst_n in the scope of use.
`ifndef GF256_POLY_INVERSE_MOD_X4_PLUS_1_MACROS_SVH
`define GF256_POLY_INVERSE_MOD_X4_PLUS_1_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GPI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GPI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gpi_pkg.sv =====
// Package for the gf256 polynomial inverse block: types, step codes, GF multiply.
// No dependencies.
package gpi_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SQ,     // square a coefficient into p0/p2
    OP_CUBE,   // accumulate a^3 = p*a
    OP_TSQ,    // t = t*t
    OP_TMS,    // t = t*s
    OP_SCALE   // c[k] = c[k]*t
  } op_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    op_t        op;
    logic [2:0] idx;
  } cmd_t;

  localparam int unsigned StepCount = 31;
  localparam int unsigned CubeBase  = 4;
  localparam int unsigned ChainBase = 12;
  localparam int unsigned FinalBase = 24;
  localparam int unsigned ScaleBase = 27;
  localparam logic [7:0]  AesReduce = 8'h1b;

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] a;
    acc = 8'h00;
    a   = x;
    for (int n = 0; n < 8; n++) begin
      if (y[n]) acc = acc ^ a;
      a = a[7] ? ({a[6:0], 1'b0} ^ AesReduce) : {a[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

// ===== src/gpi_ctrl.sv =====
// Step sequencer for the gf256 polynomial inverse block.
// Depends on gpi_pkg.
module gpi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output gpi_pkg::cmd_t   cmd
);

  gpi_pkg::state_t state_r, state_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic [4:0]      rel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpi_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '{load: 1'b0, emit: 1'b0, op: gpi_pkg::OP_NONE, idx: 3'd0};
    rel       = 5'd0;
    busy      = 1'b1;
    unique case (state_r)
      gpi_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = gpi_pkg::ST_RUN;
        end
      end
      gpi_pkg::ST_RUN: begin
        priority if (cnt_r < 5'(gpi_pkg::CubeBase)) begin
          cmd.op  = gpi_pkg::OP_SQ;
          cmd.idx = cnt_r[2:0];
        end else if (cnt_r < 5'(gpi_pkg::ChainBase)) begin
          rel     = cnt_r - 5'(gpi_pkg::CubeBase);
          cmd.op  = gpi_pkg::OP_CUBE;
          cmd.idx = rel[2:0];
        end else if (cnt_r < 5'(gpi_pkg::FinalBase)) begin
          rel    = cnt_r - 5'(gpi_pkg::ChainBase);
          cmd.op = rel[0] ? gpi_pkg::OP_TMS : gpi_pkg::OP_TSQ;
        end else if (cnt_r < 5'(gpi_pkg::ScaleBase)) begin
          cmd.op = gpi_pkg::OP_TSQ;
        end else begin
          rel     = cnt_r - 5'(gpi_pkg::ScaleBase);
          cmd.op  = gpi_pkg::OP_SCALE;
          cmd.idx = rel[2:0];
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(gpi_pkg::StepCount - 1)) state_nxt = gpi_pkg::ST_DONE;
      end
      gpi_pkg::ST_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = gpi_pkg::ST_IDLE;
      end
      default: state_nxt = gpi_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/gpi_dp.sv =====
// Datapath for the gf256 polynomial inverse block: one shared GF(2^8) multiplier.
// Depends on gpi_pkg.
module gpi_dp (
  input  logic          clk,
  input  gpi_pkg::cmd_t cmd,
  input  logic [7:0]    coef0,
  input  logic [7:0]    coef1,
  input  logic [7:0]    coef2,
  input  logic [7:0]    coef3,
  output logic [7:0]    inv0,
  output logic [7:0]    inv1,
  output logic [7:0]    inv2,
  output logic [7:0]    inv3,
  output logic          has_inv
);

  logic [7:0] a_r [4];
  logic [7:0] c_r [4];
  logic [7:0] p0_r, p2_r, t_r, s_r;
  logic [1:0] k, ai;
  logic [7:0] opa, opb, prod, a_sel, c_sel;

  assign k     = cmd.idx[1:0];
  assign ai    = (cmd.op == gpi_pkg::OP_CUBE && cmd.idx[2]) ? k + 2'd2 : k;
  assign a_sel = a_r[ai];
  assign c_sel = c_r[k];

  always_comb begin
    opa = t_r;
    opb = t_r;
    unique case (cmd.op)
      gpi_pkg::OP_SQ:    begin opa = a_sel; opb = a_sel; end
      gpi_pkg::OP_CUBE:  begin opa = cmd.idx[2] ? p2_r : p0_r; opb = a_sel; end
      gpi_pkg::OP_TMS:   opb = s_r;
      gpi_pkg::OP_SCALE: opa = c_sel;
      gpi_pkg::OP_NONE, gpi_pkg::OP_TSQ: ;
      default: ;
    endcase
  end

  assign prod = gpi_pkg::gf_mul(opa, opb);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r[0] <= coef0;
      a_r[1] <= coef1;
      a_r[2] <= coef2;
      a_r[3] <= coef3;
      s_r    <= coef0 ^ coef1 ^ coef2 ^ coef3;
      t_r    <= coef0 ^ coef1 ^ coef2 ^ coef3;
    end else begin
      unique case (cmd.op)
        gpi_pkg::OP_SQ: begin
          // a^2 mod x^4+1 keeps only even terms: p0 = a0^2+a2^2, p2 = a1^2+a3^2
          if (k[0]) p2_r <= k[1] ? (p2_r ^ prod) : prod;
          else      p0_r <= k[1] ? (p0_r ^ prod) : prod;
        end
        gpi_pkg::OP_CUBE:  c_r[k] <= cmd.idx[2] ? (c_sel ^ prod) : prod;
        gpi_pkg::OP_TSQ, gpi_pkg::OP_TMS: t_r <= prod;
        gpi_pkg::OP_SCALE: c_r[k] <= prod;
        gpi_pkg::OP_NONE: ;
        default: ;
      endcase
    end
  end

  assign has_inv = (s_r != 8'h00);
  assign inv0    = has_inv ? c_r[0] : 8'h00;
  assign inv1    = has_inv ? c_r[1] : 8'h00;
  assign inv2    = has_inv ? c_r[2] : 8'h00;
  assign inv3    = has_inv ? c_r[3] : 8'h00;

endmodule

// ===== src/gf256_poly_inverse_mod_x4_plus_1.sv =====
// Top level of the gf256 polynomial inverse block (inverse of a(x) mod x^4+1).
// Depends on gpi_pkg, gpi_ctrl, gpi_dp and the macros header.
//
// Usage: raise start with the four coefficients while busy is low; the item
// is taken at that edge and the coefficients load at that same edge.
// out_valid is high for one cycle, the last busy cycle, with the inverse
// and out_has_inverse. The receiver cannot stall, so capture it then.
// busy stays high from the accepting edge through the result cycle; one
// item is in flight at a time, and the next item can be taken in the cycle
// after the result, so a new item is not taken before the last one is
// through. busy covers 31 steps of the single shared GF(2^8) multiplier
// and the result cycle. Method:
// with s = a(1), a^4 = s^4 in this ring, so
// a^-1 = a^3 * s^-4; s^-4 comes from an addition chain to s^127 followed by
// three squarings. s = 0 means no inverse: flag 0, coefficients 0.
`include "gf256_poly_inverse_mod_x4_plus_1_macros.svh"

module gf256_poly_inverse_mod_x4_plus_1 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_coef0,
  input  logic [7:0] in_coef1,
  input  logic [7:0] in_coef2,
  input  logic [7:0] in_coef3,
  output logic       out_valid,
  output logic [7:0] out_inv0,
  output logic [7:0] out_inv1,
  output logic [7:0] out_inv2,
  output logic [7:0] out_inv3,
  output logic       out_has_inverse
);

  gpi_pkg::cmd_t cmd;

  gpi_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  gpi_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .coef0   (in_coef0),
    .coef1   (in_coef1),
    .coef2   (in_coef2),
    .coef3   (in_coef3),
    .inv0    (out_inv0),
    .inv1    (out_inv1),
    .inv2    (out_inv2),
    .inv3    (out_inv3),
    .has_inv (out_has_inverse)
  );

  // result is shown only in the last busy cycle
  assign out_valid = cmd.emit;

  `GPI_ASSERT_NXT(a_accept_busy, start && !busy, busy && !out_valid, "item not held busy")
  `GPI_ASSERT_NXT(a_emit_idle, out_valid, !busy, "not idle after result")
  `GPI_ASSERT_IMP(a_emit_busy, out_valid, busy, "result outside busy window")
  `GPI_ASSERT_IMP(a_no_inv_zero, out_valid && !out_has_inverse,
    out_inv0 == 8'h00 && out_inv1 == 8'h00 && out_inv2 == 8'h00 && out_inv3 == 8'h00,
    "nonzero result without inverse")

endmodule
